@@ sv/s2a_pkg.sv @@
package s2a_pkg;

    localparam int NUM_POS = 5;
    localparam logic [6:0] CHAR_ZERO  = 7'd48;
    localparam logic [6:0] CHAR_MINUS = 7'd45;
    localparam logic [2:0] LAST_POS   = 3'(NUM_POS - 1);

    typedef struct packed {
        logic        neg;
        logic [15:0] mag;
    } item_t;

    // k times the power of ten for one digit position, k = 0..9
    typedef logic [9:0][16:0] mult_row_t;

    function automatic mult_row_t build_row(input int p);
        mult_row_t r;
        int pw;
        pw = 1;
        for (int i = 0; i < NUM_POS - 1 - p; i++)
        begin
            pw = pw * 10;
        end
        for (int k = 0; k < 10; k++)
        begin
            r[k] = 17'(k * pw);
        end
        return r;
    endfunction

    localparam mult_row_t MULT_TABLE [NUM_POS] = '{
        build_row(0), build_row(1), build_row(2), build_row(3), build_row(4)
    };

endpackage

@@ sv/s2a_front.sv @@
module s2a_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [15:0]     value,
    output logic            busy,
    output logic            q_valid,
    output s2a_pkg::item_t  q_item,
    input  logic            q_pop
);
    import s2a_pkg::*;

    item_t       entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    item_t       classified;
    logic        push;
    logic        pop;

    // split sign and magnitude; the most negative value wraps to 0x8000, which is its magnitude
    always_comb
    begin
        classified.neg = value[15];
        classified.mag = value[15] ? 16'(-value) : value;
    end

    assign busy    = (count_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign pop     = q_pop && q_valid;
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

@@ sv/s2a_back.sv @@
module s2a_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  s2a_pkg::item_t  q_item,
    output logic            q_pop,
    output logic            strobe,
    output logic [6:0]      ascii_char,
    output logic            last_char
);
    import s2a_pkg::*;

    logic        active_reg, active_next;
    logic        sign_reg, sign_next;
    logic        started_reg, started_next;
    logic [2:0]  pos_reg, pos_next;
    logic [15:0] rem_reg, rem_next;
    logic        strobe_reg, strobe_next;
    logic [6:0]  char_reg, char_next;
    logic        last_reg, last_next;

    mult_row_t   row;
    logic [3:0]  digit;
    logic [16:0] sub;
    logic        finishing;

    assign row = MULT_TABLE[pos_reg];

    // largest multiple of the current power that fits in the remainder
    always_comb
    begin
        digit = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if ({1'b0, rem_reg} >= row[k])
            begin
                digit = 4'(k);
            end
        end
        sub = row[digit];
    end

    assign finishing = active_reg && !sign_reg && (pos_reg == LAST_POS);
    assign q_pop     = q_valid && (!active_reg || finishing);

    always_comb
    begin
        active_next  = active_reg;
        sign_next    = sign_reg;
        started_next = started_reg;
        pos_next     = pos_reg;
        rem_next     = rem_reg;
        strobe_next  = 1'b0;
        char_next    = char_reg;
        last_next    = last_reg;

        if (active_reg)
        begin
            if (sign_reg)
            begin
                strobe_next = 1'b1;
                char_next   = CHAR_MINUS;
                last_next   = 1'b0;
                sign_next   = 1'b0;
            end
            else
            begin
                // drop leading zeros, but always give the units digit
                strobe_next  = (digit != 4'd0) || started_reg || (pos_reg == LAST_POS);
                char_next    = CHAR_ZERO + 7'(digit);
                last_next    = (pos_reg == LAST_POS);
                started_next = started_reg || (digit != 4'd0);
                rem_next     = rem_reg - sub[15:0];
                // hold the position on the units digit so the table index stays in range
                pos_next     = finishing ? pos_reg : pos_reg + 3'd1;
                if (finishing)
                begin
                    active_next = 1'b0;
                end
            end
        end

        if (q_pop)
        begin
            active_next  = 1'b1;
            sign_next    = q_item.neg;
            started_next = 1'b0;
            pos_next     = 3'd0;
            rem_next     = q_item.mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            sign_reg    <= 1'b0;
            started_reg <= 1'b0;
            pos_reg     <= 3'd0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            sign_reg    <= sign_next;
            started_reg <= started_next;
            pos_reg     <= pos_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign strobe     = strobe_reg;
    assign ascii_char = char_reg;
    assign last_char  = last_reg;

`ifndef NO_ASSERTIONS
    a_units_closes: assert property (@(posedge clk) disable iff (!rst_n)
        finishing |=> (strobe_reg && last_reg))
        else $error("units digit not emitted as final item");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |=> !strobe_reg)
        else $error("item emitted while back end idle");

    a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && last_reg) |-> (char_reg != CHAR_MINUS))
        else $error("sign flagged as final item");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (pos_reg <= LAST_POS))
        else $error("digit position out of range");
`endif

endmodule

@@ sv/signed_int_to_decimal_ascii.sv @@
// Renders each signed 16-bit value as decimal ASCII text, one character per
// strobe cycle, with last_char marking the final character; the receiver
// cannot stall, so every strobe must be taken. A value is accepted when start
// is high and busy is low; a two-entry queue holds accepted values while the
// digit unit works. The digit unit takes the sign of a negative value as a
// step of its own and then each of the five digit positions in turn (leading
// zeros give no strobe), and a queued value starts straight after the last
// position. When the digit unit is idle, an accepted value passes through the
// queue entry and the digit unit's registers before its first character is
// registered; each suppressed leading zero of a positive value delays it further.
module signed_int_to_decimal_ascii (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] value,
    output logic        strobe,
    output logic [6:0]  ascii_char,
    output logic        last_char
);
    import s2a_pkg::*;

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    s2a_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .value   (value),
        .busy    (busy),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    s2a_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .strobe     (strobe),
        .ascii_char (ascii_char),
        .last_char  (last_char)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import s2a_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 63;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } text_char_t;

    typedef struct {
        int    val;
        string text;
    } text_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] value;
    logic        strobe;
    logic [6:0]  ascii_char;
    logic        last_char;

    text_char_t  char_q[$];
    int          n_fail;
    int          n_values;
    int          n_negative;
    int          n_chars;
    int          idle_cycles;

    // An empty text means the row is checked against the predictor.
    text_row_t   directed_rows[] = '{
        '{0,      "0"},
        '{1,      "1"},
        '{-1,     "-1"},
        '{9,      "9"},
        '{10,     "10"},
        '{-10,    "-10"},
        '{99,     "99"},
        '{100,    "100"},
        '{1000,   "1000"},
        '{9999,   "9999"},
        '{10000,  "10000"},
        '{-10000, "-10000"},
        '{32767,  "32767"},
        '{-32768, "-32768"},
        '{-32767, "-32767"},
        '{10001,  ""},
        '{20305,  ""},
        '{-1005,  ""},
        '{12345,  ""},
        '{-6,     ""},
        '{21845,  ""},
        '{-21846, ""}
    };

    signed_int_to_decimal_ascii DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .strobe     (strobe),
        .ascii_char (ascii_char),
        .last_char  (last_char)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void push_char(logic [6:0] code, logic last);
        text_char_t c;
        c.code = code;
        c.last = last;
        char_q.push_back(c);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_char(7'(s[i]), i == s.len() - 1);
        end
    endfunction

    // Expected decimal text of one value: sign, then digits without leading zeros.
    function automatic void render_decimal(logic [15:0] v);
        logic neg;
        int   mag;
        int   pw;
        int   digit;
        neg = v[15];
        mag = neg ? 65536 - int'(v) : int'(v);
        if (mag == 0)
        begin
            push_char(CHAR_ZERO, 1'b1);
            return;
        end
        if (neg)
        begin
            push_char(CHAR_MINUS, 1'b0);
        end
        pw = 10000;
        while (pw > mag)
        begin
            pw = pw / 10;
        end
        while (pw > 0)
        begin
            digit = mag / pw;
            mag   = mag - digit * pw;
            push_char(CHAR_ZERO + 7'(digit), (pw / 10) == 0);
            pw    = pw / 10;
        end
    endfunction

    // Mostly values of a chosen digit count, some extremes, some raw bit patterns.
    function automatic logic [15:0] pick_value();
        int n;
        int pw;
        int lo;
        int hi;
        int m;
        int extremes[7] = '{0, -32768, 32767, -1, 1, 10000, -10000};
        case ($urandom_range(9, 0))
            0:
            begin
                return 16'(extremes[$urandom_range(6, 0)]);
            end
            1, 2, 3, 4, 5, 6:
            begin
                n  = $urandom_range(5, 1);
                pw = 1;
                repeat (n - 1) pw = pw * 10;
                lo = pw;
                hi = (n == 5) ? 32767 : pw * 10 - 1;
                m  = $urandom_range(hi, lo);
                return $urandom_range(1, 0) ? 16'(-m) : 16'(m);
            end
            default:
            begin
                return 16'($urandom);
            end
        endcase
    endfunction

    function automatic int idle_gap(int pct);
        int gap;
        gap = 0;
        while ($urandom_range(99, 0) < pct)
        begin
            gap++;
        end
        return gap;
    endfunction

    // Hold start until the block takes the item, then log its expected text.
    task automatic send_value(logic [15:0] v, string text, int pct);
        int gap;
        gap = idle_gap(pct);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (text.len() > 0)
        begin
            push_text(text);
        end
        else
        begin
            render_decimal(v);
        end
        n_values++;
        if (v[15])
        begin
            n_negative++;
        end
    endtask

    always @(posedge clk)
    begin
        text_char_t exp_c;
        if (rst_n && strobe === 1'b1)
        begin
            n_chars++;
            if (char_q.size() == 0)
            begin
                $error("unexpected character: ascii_char %0d, last_char %0d",
                       ascii_char, last_char);
                n_fail++;
            end
            else
            begin
                exp_c = char_q.pop_front();
                if (ascii_char !== exp_c.code)
                begin
                    $error("ascii_char: expected %0d, got %0d", exp_c.code, ascii_char);
                    n_fail++;
                end
                if (last_char !== exp_c.last)
                begin
                    $error("last_char: expected %0d, got %0d", exp_c.last, last_char);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && busy === 1'b0) || strobe === 1'b1)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[signed_int_to_decimal_ascii] ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        value       = '0;
        n_fail      = 0;
        n_values    = 0;
        n_negative  = 0;
        n_chars     = 0;
        idle_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_value(16'(directed_rows[i].val), directed_rows[i].text, 11);
        end

        // Sender idles lightly, then heavily, then not at all.
        for (int i = 0; i < 3 * PHASE_ITEMS; i++)
        begin
            send_value(pick_value(), "",
                       (i < PHASE_ITEMS) ? 11 : (i < 2 * PHASE_ITEMS) ? 46 : 0);
        end
        start <= 1'b0;

        while (char_q.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Rendered %0d values (%0d negative), %0d characters checked against text",
                 n_values, n_negative, n_chars);
        if (n_fail == 0)
        begin
            $display("[signed_int_to_decimal_ascii] OK");
        end
        else
        begin
            $display("[signed_int_to_decimal_ascii] ERROR");
        end
        $finish;
    end

endmodule
